FILE: rtl/bsc_pkg.sv
// shared types, widths and constants of the barometer compensation pipeline
package bsc_pkg;

	localparam int D_W       = 24;   // raw conversion width
	localparam int C_W       = 16;   // calibration word width
	localparam int DT_W      = D_W + 1;
	localparam int PROD_W    = DT_W + C_W + 1;
	localparam int SQP_W     = 2 * DT_W;
	localparam int T_W       = 19;   // temperature width
	localparam int T2_W      = 18;
	localparam int OFF1_W    = 36;
	localparam int SENS1_W   = 36;
	localparam int SQ_W      = 36;
	localparam int CORR_W    = 40;
	localparam int OFF_W     = 42;
	localparam int SENS_W    = 41;
	localparam int P_W       = 32;   // pressure result width

	localparam int TEMP_SHIFT = 23;
	localparam int OFF_SHIFT  = 7;
	localparam int SENS_SHIFT = 8;
	localparam int T2_SHIFT   = 31;
	localparam int C5_SHIFT   = 8;
	localparam int C2_SHIFT   = 16;
	localparam int C1_SHIFT   = 15;
	localparam int P1_SHIFT   = 21;
	localparam int P2_SHIFT   = 15;

	localparam int TEMP_BASE    = 2000;
	localparam int TEMP_LOW_OFS = 3500;  // base plus the low-temperature knee of 1500

	// final multiply split: low slice matches the first pressure shift
	localparam int SLO_W = P1_SHIFT;
	localparam int SHI_W = SENS_W - SLO_W;
	localparam int LO_W  = D_W + SLO_W;
	localparam int HI_W  = D_W + 1 + SHI_W;
	localparam int Q_W   = HI_W + 1;
	localparam int X_W   = P_W + P2_SHIFT + 1;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_C1 = 3'd0,
		REG_C2 = 3'd1,
		REG_C3 = 3'd2,
		REG_C4 = 3'd3,
		REG_C5 = 3'd4,
		REG_C6 = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [C_W-1:0] c1;
		logic [C_W-1:0] c2;
		logic [C_W-1:0] c3;
		logic [C_W-1:0] c4;
		logic [C_W-1:0] c5;
		logic [C_W-1:0] c6;
	} coef_t;

	// first-order terms handed to the second-order correction
	typedef struct packed {
		logic                      ok;
		logic [D_W-1:0]            d1;
		logic signed [T_W-1:0]     temp1;
		logic signed [T_W-1:0]     dta;    // temp1 - 2000
		logic signed [T_W-1:0]     dtb;    // temp1 + 1500
		logic                      lt;
		logic                      lt2;
		logic [T2_W-1:0]           t2;
		logic signed [OFF1_W-1:0]  off1;
		logic signed [SENS1_W-1:0] sens1;
	} front_t;

	// corrected terms handed to the pressure stages
	typedef struct packed {
		logic                     ok;
		logic [D_W-1:0]           d1;
		logic signed [T_W-1:0]    temp;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
	} mid_t;

endpackage

FILE: rtl/baro_sensor_compensation_top.sv
// top level of the barometer compensation pipeline with calibration registers
// Barometer compensation: takes a raw pressure and raw temperature conversion pair as one
// item and returns compensated temperature (hundredths of a degree C) and pressure
// (hundredths of a millibar, clamped to signed 32 bits), with result_valid low and both
// values zero when either raw value is zero. The six calibration words are loaded through
// the cfg port (index 0..5, C1..C6, other indexes ignored); the user must load them only
// while no item is in flight, which the block itself does not enforce. The datapath is a
// ten-stage pipeline: three stages for the first-order terms, three for the second-order
// correction and four for the pressure multiply, offset and clamp. One item is taken every
// cycle while the first stage is free to move; out_valid is the valid flag of the last
// stage. Each stage holds its item under back-pressure, so empty stages still take new
// items while a finished result waits at the output register.
module baro_sensor_compensation_top import bsc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// calibration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [C_W-1:0]        cfg_data,
	// input items
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [D_W-1:0]        raw_pressure,
	input  logic [D_W-1:0]        raw_temperature,
	// result items
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [T_W-1:0] temperature_centi,
	output logic signed [P_W-1:0] pressure_centi,
	output logic                  result_valid
);

	coef_t  coef_q;

	// links between the three pipeline sections
	logic   fr_valid, fr_ready;
	front_t fr_data;
	logic   md_valid, md_ready;
	mid_t   md_data;

	// calibration words, reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_C1: coef_q.c1 <= cfg_data;
				REG_C2: coef_q.c2 <= cfg_data;
				REG_C3: coef_q.c3 <= cfg_data;
				REG_C4: coef_q.c4 <= cfg_data;
				REG_C5: coef_q.c5 <= cfg_data;
				REG_C6: coef_q.c6 <= cfg_data;
				default: ;  // unused indexes are ignored
			endcase
		end
	end

	// dt, the four products and the first-order temperature, offset and sensitivity
	bsc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.coef            (coef_q),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.out_valid       (fr_valid),
		.out_ready       (fr_ready),
		.out_data        (fr_data)
	);

	// low-temperature squares and corrections
	bsc_second u_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_data   (fr_data),
		.out_valid (md_valid),
		.out_ready (md_ready),
		.out_data  (md_data)
	);

	// pressure multiply, scaling, clamp and output register
	bsc_press u_press (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (md_valid),
		.in_ready          (md_ready),
		.in_data           (md_data),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.temperature_centi (temperature_centi),
		.pressure_centi    (pressure_centi),
		.result_valid      (result_valid)
	);

`ifndef ASSERT_OFF
	// a flagged-invalid result carries zero values
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !result_valid) |-> (temperature_centi == '0 && pressure_centi == '0))
		else $error("invalid result with nonzero values");

	// with the output free, every stage can move, so the input must be open
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input blocked while output is free");

	// an item never leaves the first section while the second one holds
	a_link_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fr_valid && !fr_ready) |=> fr_valid && $stable(fr_data))
		else $error("first section dropped an item under stall");
`endif

endmodule

FILE: rtl/bsc_front.sv
// first-order compensation: dt, products and first-order terms, three stages
module bsc_front import bsc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  coef_t          coef,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [D_W-1:0] raw_pressure,
	input  logic [D_W-1:0] raw_temperature,
	output logic           out_valid,
	input  logic           out_ready,
	output front_t         out_data
);

	logic                     v_s1, v_s2, v_s3;
	logic                     rdy_s1, rdy_s2, rdy_s3;
	logic                     ok_s1, ok_s2;
	logic [D_W-1:0]           d1_s1, d1_s2;
	logic signed [DT_W-1:0]   dt_s1;
	logic signed [PROD_W-1:0] p6_s2, p4_s2, p3_s2;
	logic signed [SQP_W-1:0]  pdd_s2;
	front_t                   f_s3;

	logic signed [DT_W-1:0]   dt_c;
	logic signed [C_W:0]      c6_c, c4_c, c3_c;
	front_t                   f_c;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign dt_c = $signed({1'b0, raw_temperature}) - $signed({1'b0, coef.c5, C5_SHIFT'(0)});
	assign c6_c = $signed({1'b0, coef.c6});
	assign c4_c = $signed({1'b0, coef.c4});
	assign c3_c = $signed({1'b0, coef.c3});

	always_comb begin
		f_c       = '0;
		f_c.ok    = ok_s2;
		f_c.d1    = d1_s2;
		f_c.dta   = p6_s2[PROD_W-1:TEMP_SHIFT];
		f_c.temp1 = f_c.dta + T_W'(TEMP_BASE);
		f_c.dtb   = f_c.dta + T_W'(TEMP_LOW_OFS);
		f_c.lt    = f_c.dta[T_W-1];
		f_c.lt2   = f_c.dtb[T_W-1];
		f_c.t2    = pdd_s2[T2_SHIFT+T2_W-1:T2_SHIFT];
		f_c.off1  = $signed(OFF1_W'(coef.c2) << C2_SHIFT)
			+ OFF1_W'($signed(p4_s2[PROD_W-1:OFF_SHIFT]));
		f_c.sens1 = $signed(SENS1_W'(coef.c1) << C1_SHIFT)
			+ SENS1_W'($signed(p3_s2[PROD_W-1:SENS_SHIFT]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			ok_s1 <= (raw_pressure != '0) && (raw_temperature != '0);
			d1_s1 <= raw_pressure;
			dt_s1 <= dt_c;
		end
		if (rdy_s2 && v_s1) begin
			ok_s2  <= ok_s1;
			d1_s2  <= d1_s1;
			p6_s2  <= dt_s1 * c6_c;
			p4_s2  <= dt_s1 * c4_c;
			p3_s2  <= dt_s1 * c3_c;
			pdd_s2 <= dt_s1 * dt_s1;
		end
		if (rdy_s3 && v_s2) begin
			f_s3 <= f_c;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = f_s3;

endmodule

FILE: rtl/bsc_second.sv
// second-order correction: squares, correction terms and subtraction, three stages
module bsc_second import bsc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  front_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output mid_t   out_data
);

	logic                   v_s4, v_s5, v_s6;
	logic                   rdy_s4, rdy_s5, rdy_s6;
	front_t                 f_s4, f_s5;
	logic [SQ_W-1:0]        sqa_s4, sqb_s4;
	logic [CORR_W-1:0]      off2_s5, sens2_s5;
	mid_t                   m_s6;

	logic signed [2*T_W-1:0] sqa_c, sqb_c;
	logic [CORR_W-1:0]       a5_c, b7_c, b11_c, off2_c, sens2_c;
	mid_t                    m_c;

	assign rdy_s6   = !v_s6 || out_ready;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign in_ready = rdy_s4;

	assign sqa_c = $signed(in_data.dta) * $signed(in_data.dta);
	assign sqb_c = $signed(in_data.dtb) * $signed(in_data.dtb);

	// constant multiples by shift, add and subtract
	always_comb begin
		a5_c    = (CORR_W'(sqa_s4) << 2) + CORR_W'(sqa_s4);
		b7_c    = (CORR_W'(sqb_s4) << 3) - CORR_W'(sqb_s4);
		b11_c   = (CORR_W'(sqb_s4) << 3) + (CORR_W'(sqb_s4) << 1) + CORR_W'(sqb_s4);
		off2_c  = (a5_c >> 1) + (f_s4.lt2 ? b7_c : '0);
		sens2_c = (a5_c >> 2) + (f_s4.lt2 ? (b11_c >> 1) : '0);
	end

	// corrections only apply below the 20 degree knee
	always_comb begin
		m_c      = '0;
		m_c.ok   = f_s5.ok;
		m_c.d1   = f_s5.d1;
		m_c.temp = f_s5.temp1 - (f_s5.lt ? $signed({1'b0, f_s5.t2}) : T_W'(0));
		m_c.off  = OFF_W'($signed(f_s5.off1)) - (f_s5.lt ? OFF_W'(off2_s5) : OFF_W'(0));
		m_c.sens = SENS_W'($signed(f_s5.sens1)) - (f_s5.lt ? SENS_W'(sens2_s5) : SENS_W'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s4) v_s4 <= in_valid;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && in_valid) begin
			f_s4   <= in_data;
			sqa_s4 <= sqa_c[SQ_W-1:0];
			sqb_s4 <= sqb_c[SQ_W-1:0];
		end
		if (rdy_s5 && v_s4) begin
			f_s5     <= f_s4;
			off2_s5  <= off2_c;
			sens2_s5 <= sens2_c;
		end
		if (rdy_s6 && v_s5) begin
			m_s6 <= m_c;
		end
	end

	assign out_valid = v_s6;
	assign out_data  = m_s6;

endmodule

FILE: rtl/bsc_press.sv
// pressure stages: split multiply, scaling, offset, saturation and output register
module bsc_press import bsc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  mid_t                  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [T_W-1:0] temperature_centi,
	output logic signed [P_W-1:0] pressure_centi,
	output logic                  result_valid
);

	logic                    v_s7, v_s8, v_s9, v_s10;
	logic                    rdy_s7, rdy_s8, rdy_s9, rdy_s10;
	logic                    ok_s7, ok_s8, ok_s9;
	logic signed [T_W-1:0]   temp_s7, temp_s8, temp_s9;
	logic signed [OFF_W-1:0] off_s7, off_s8;
	logic [LO_W-1:0]         lo_s7;
	logic signed [HI_W-1:0]  hi_s7;
	logic signed [Q_W-1:0]   q_s8;
	logic signed [X_W-1:0]   x_s9;
	logic signed [T_W-1:0]   temp_s10;
	logic signed [P_W-1:0]   p_s10;
	logic                    ok_s10;

	logic signed [SHI_W-1:0] shi_c;
	logic signed [P_W:0]     sh_c;
	logic signed [P_W-1:0]   p_c;

	assign rdy_s10  = !v_s10 || out_ready;
	assign rdy_s9   = !v_s9 || rdy_s10;
	assign rdy_s8   = !v_s8 || rdy_s9;
	assign rdy_s7   = !v_s7 || rdy_s8;
	assign in_ready = rdy_s7;

	assign shi_c = in_data.sens[SENS_W-1:SLO_W];

	// floor shift of the scaled product minus the offset, then clamp to 32 bits
	always_comb begin
		sh_c = x_s9[X_W-1:P2_SHIFT];
		if (sh_c[P_W] != sh_c[P_W-1]) begin
			p_c = sh_c[P_W] ? {1'b1, {(P_W-1){1'b0}}} : {1'b0, {(P_W-1){1'b1}}};
		end else begin
			p_c = sh_c[P_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (rdy_s7)  v_s7  <= in_valid;
			if (rdy_s8)  v_s8  <= v_s7;
			if (rdy_s9)  v_s9  <= v_s8;
			if (rdy_s10) v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s7 && in_valid) begin
			ok_s7   <= in_data.ok;
			temp_s7 <= in_data.temp;
			off_s7  <= in_data.off;
			lo_s7   <= in_data.d1 * in_data.sens[SLO_W-1:0];
			hi_s7   <= $signed({1'b0, in_data.d1}) * shi_c;
		end
		if (rdy_s8 && v_s7) begin
			ok_s8   <= ok_s7;
			temp_s8 <= temp_s7;
			off_s8  <= off_s7;
			q_s8    <= Q_W'(hi_s7) + $signed(Q_W'(lo_s7[LO_W-1:SLO_W]));
		end
		if (rdy_s9 && v_s8) begin
			ok_s9   <= ok_s8;
			temp_s9 <= temp_s8;
			x_s9    <= X_W'(q_s8) - X_W'(off_s8);
		end
		if (rdy_s10 && v_s9) begin
			ok_s10   <= ok_s9;
			temp_s10 <= ok_s9 ? temp_s9 : T_W'(0);
			p_s10    <= ok_s9 ? p_c : P_W'(0);
		end
	end

	assign out_valid         = v_s10;
	assign temperature_centi = temp_s10;
	assign pressure_centi    = p_s10;
	assign result_valid      = ok_s10;

endmodule

FILE: verif/bsc_result_checker.sv
`timescale 1ns / 100ps
// checker for the barometer compensation block: predicts each reading and compares it
module bsc_result_checker import bsc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [C_W-1:0]        cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [D_W-1:0]        raw_pressure,
	input  logic [D_W-1:0]        raw_temperature,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic signed [T_W-1:0] temperature_centi,
	input  logic signed [P_W-1:0] pressure_centi,
	input  logic                  result_valid,
	output int                    mismatches,
	output int                    pending
);

	localparam longint P_MAX = 64'sd2147483647;
	localparam longint P_MIN = -64'sd2147483648;
	localparam int     MAX_REPORTS = 40;

	typedef struct packed {
		logic                  ok;
		logic signed [T_W-1:0] temp;
		logic signed [P_W-1:0] press;
	} reading_t;

	coef_t    cal;
	reading_t expected_readings[$];
	int       n_out;

	initial begin
		mismatches = 0;
		pending    = 0;
		n_out      = 0;
	end

	// first and second order compensation, all at 64 bits
	function automatic reading_t compensate(input coef_t c, input logic [D_W-1:0] d1_raw,
		input logic [D_W-1:0] d2_raw);
		longint   d1, d2, dt, temp, off, sens, t2, off2, sens2, sq, p;
		reading_t r;
		r  = '0;
		d1 = longint'(d1_raw);
		d2 = longint'(d2_raw);
		if (d1 == 0 || d2 == 0)
			return r;
		dt   = d2 - (longint'(c.c5) << 8);
		temp = 2000 + ((dt * longint'(c.c6)) >>> 23);
		off  = (longint'(c.c2) << 16) + ((longint'(c.c4) * dt) >>> 7);
		sens = (longint'(c.c1) << 15) + ((longint'(c.c3) * dt) >>> 8);
		t2    = 0;
		off2  = 0;
		sens2 = 0;
		// cold correction, with an extra term below the low knee
		if (temp < 2000) begin
			t2    = (dt * dt) >>> 31;
			sq    = (temp - 2000) * (temp - 2000);
			off2  = (5 * sq) >>> 1;
			sens2 = (5 * sq) >>> 2;
			if (temp < -1500) begin
				sq    = (temp + 1500) * (temp + 1500);
				off2  = off2 + 7 * sq;
				sens2 = sens2 + ((11 * sq) >>> 1);
			end
		end
		temp = temp - t2;
		off  = off - off2;
		sens = sens - sens2;
		p = (((d1 * sens) >>> 21) - off) >>> 15;
		if (p > P_MAX)
			p = P_MAX;
		else if (p < P_MIN)
			p = P_MIN;
		r.ok    = 1'b1;
		r.temp  = temp[T_W-1:0];
		r.press = p[P_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t mismatch on result %0d: %s got %0d expected %0d",
				$time, n_out, what, got, want);
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_C1: cal.c1 <= cfg_data;
				REG_C2: cal.c2 <= cfg_data;
				REG_C3: cal.c3 <= cfg_data;
				REG_C4: cal.c4 <= cfg_data;
				REG_C5: cal.c5 <= cfg_data;
				REG_C6: cal.c6 <= cfg_data;
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		reading_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_readings.push_back(compensate(cal, raw_pressure, raw_temperature));
			if (out_valid && out_ready) begin
				n_out++;
				if (expected_readings.size() == 0) begin
					report_mismatch("reading with nothing expected, count", n_out, 0);
				end else begin
					want = expected_readings.pop_front();
					if (result_valid !== want.ok)
						report_mismatch("result_valid", result_valid, want.ok);
					if (temperature_centi !== want.temp)
						report_mismatch("temperature_centi", temperature_centi, want.temp);
					if (pressure_centi !== want.press)
						report_mismatch("pressure_centi", pressure_centi, want.press);
				end
			end
			pending <= expected_readings.size();
		end
	end

endmodule

FILE: verif/baro_sensor_compensation_top_test.sv
`timescale 1ns / 100ps
// stimulus and verdict for the barometer compensation block
module baro_sensor_compensation_top_test import bsc_pkg::*;;

	localparam int RESET_CYCLES = 7;
	localparam int STALL_LIMIT  = 3000;  // cycles with no item moving before giving up
	localparam int HOLD_AFTER   = 150;   // items sent before the long output stall
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 24;    // a bit over twice the pipeline depth

	// indexes past the last calibration word, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

	localparam logic [D_W-1:0] RAW_MAX = 24'hFFFFFF;

	logic                  clk             = 1'b0;
	logic                  arst_n          = 1'b0;
	logic                  cfg_we          = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index       = '0;
	logic [C_W-1:0]        cfg_data        = '0;
	logic                  in_valid        = 1'b0;
	logic                  in_ready;
	logic [D_W-1:0]        raw_pressure    = '0;
	logic [D_W-1:0]        raw_temperature = '0;
	logic                  out_valid;
	logic                  out_ready       = 1'b0;
	logic signed [T_W-1:0] temperature_centi;
	logic signed [P_W-1:0] pressure_centi;
	logic                  result_valid;

	int       mismatches;
	int       pending;
	int       items_sent  = 0;
	int       idle_cycles = 0;
	bit       calm_tx     = 1'b0;  // sender offers back to back while set
	logic [C_W-1:0] ref_word = '0;  // current reference temperature word, for aiming

	always #1 clk = ~clk;

	baro_sensor_compensation_top i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.raw_pressure      (raw_pressure),
		.raw_temperature   (raw_temperature),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.temperature_centi (temperature_centi),
		.pressure_centi    (pressure_centi),
		.result_valid      (result_valid)
	);

	bsc_result_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.raw_pressure      (raw_pressure),
		.raw_temperature   (raw_temperature),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.temperature_centi (temperature_centi),
		.pressure_centi    (pressure_centi),
		.result_valid      (result_valid),
		.mismatches        (mismatches),
		.pending           (pending)
	);

	// gap length: mostly none or short, now and then long
	function automatic int idle_len(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// calibration word biased toward the extremes
	function automatic logic [C_W-1:0] pick_word();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			default: return C_W'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [C_W-1:0] word);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		@(posedge clk);
		if (idx == REG_C5)
			ref_word = word;
	endtask

	// full calibration load, plus junk on the unused indexes
	task automatic load_cal(input logic [C_W-1:0] w1, w2, w3, w4, w5, w6);
		write_cal(REG_C1, w1);
		write_cal(IDX_SPARE_A, C_W'($urandom_range(0, 16'hFFFF)));
		write_cal(REG_C2, w2);
		write_cal(REG_C3, w3);
		write_cal(REG_C4, w4);
		write_cal(REG_C5, w5);
		write_cal(REG_C6, w6);
		write_cal(IDX_SPARE_B, C_W'($urandom_range(0, 16'hFFFF)));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// offer one raw pair after a random gap, hold it until taken
	task automatic send_pair(input logic [D_W-1:0] d1, input logic [D_W-1:0] d2);
		int gap;
		gap = idle_len(calm_tx);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		raw_pressure    <= d1;
		raw_temperature <= d2;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// stop offering and wait for every reading to come back
	task automatic drain_phase();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic send_random(input int n);
		logic [D_W-1:0] d1, d2;
		int             r, k;
		longint         aim;
		for (int i = 0; i < n; i++) begin
			if (i % 48 == 0)
				calm_tx = ($urandom_range(0, 3) == 0);
			r  = $urandom_range(0, 99);
			d1 = D_W'($urandom_range(1, RAW_MAX));
			d2 = D_W'($urandom_range(1, RAW_MAX));
			if (r < 6) begin
				// a missing conversion on one side or both
				case ($urandom_range(0, 2))
					0:       d1 = '0;
					1:       d2 = '0;
					default: begin
						d1 = '0;
						d2 = '0;
					end
				endcase
			end else if (r < 16) begin
				// range ends of the raw values
				if ($urandom_range(0, 1))
					d1 = $urandom_range(0, 1) ? RAW_MAX : D_W'(1);
				if ($urandom_range(0, 1))
					d2 = $urandom_range(0, 1) ? RAW_MAX : D_W'(1);
			end else if (r < 45) begin
				// temperature near the reference point, either side, any distance
				k   = $urandom_range(0, 23);
				aim = longint'(ref_word) * 256 + longint'($urandom_range(0, 2 ** (k + 1)))
					- (longint'(1) << k);
				if (aim < 1)
					aim = 1;
				if (aim > longint'(RAW_MAX))
					aim = longint'(RAW_MAX);
				d2 = aim[D_W-1:0];
			end
			send_pair(d1, d2);
		end
	endtask

	// no item moving for too long means a hang
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", idle_cycles);
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: ready runs and gaps, one long stall to back the pipeline up
	initial begin
		int run, gap;
		bit held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			if (!held && items_sent >= HOLD_AFTER) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
				out_ready <= 1'b1;
				repeat (run) begin
					@(posedge clk);
					// cut the run short once the long stall is due
					if (!held && items_sent >= HOLD_AFTER)
						break;
				end
				gap = idle_len(1'b0);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// calibration still at reset, all words zero
		send_pair('0, '0);
		send_pair(D_W'(1), D_W'(1));
		send_pair(RAW_MAX, RAW_MAX);
		send_pair('0, D_W'(8569150));
		send_pair(D_W'(9085466), '0);
		send_random(50);
		drain_phase();

		// typical factory calibration
		load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
		send_pair(D_W'(9085466), D_W'(8569150));  // room temperature
		send_pair(D_W'(1), D_W'(1));              // deep cold, smallest pressure
		send_pair(RAW_MAX, RAW_MAX);              // hot, largest pressure
		send_pair(RAW_MAX, D_W'(1));
		send_pair(D_W'(1), RAW_MAX);
		send_pair(24'hAAAAAA, 24'h555555);
		send_pair(24'h555555, 24'hAAAAAA);
		send_pair(D_W'(9085466), D_W'(8566784));  // exactly at the reference, no correction
		send_pair(D_W'(9085466), D_W'(8566783));  // just below it, first cold branch
		send_pair(D_W'(9085466), D_W'(7529764));  // sits on the low knee
		send_pair(D_W'(9085466), D_W'(7529763));  // one step past the low knee
		send_random(110);
		drain_phase();

		// every word at its top value
		load_cal('1, '1, '1, '1, '1, '1);
		send_random(110);
		drain_phase();

		// alternating bit patterns, then the complement
		load_cal(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
		send_random(100);
		drain_phase();
		load_cal(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
		send_random(100);
		drain_phase();

		// random mixes of zero, full scale and anything
		repeat (2) begin
			load_cal(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), pick_word());
			send_random(110);
			drain_phase();
		end

		// all words written back to zero
		load_cal('0, '0, '0, '0, '0, '0);
		send_random(40);
		drain_phase();

		// let any stray reading show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/bsc_pkg.sv
rtl/bsc_front.sv
rtl/bsc_second.sv
rtl/bsc_press.sv
rtl/baro_sensor_compensation_top.sv
verif/bsc_result_checker.sv
verif/baro_sensor_compensation_top_test.sv
